// ===== hdl/fbrd_pkg.sv =====
// Shared types, codes and helpers for the raster draw engine.
// Used by every other file of the block but fbrd_checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package fbrd_pkg;

  localparam int COORD_W = 16;
  localparam int COLOR_W = 16;
  localparam int RAD_W   = 10;
  localparam int OP_W    = 3;

  localparam logic [OP_W-1:0] OP_PLOT = 3'd0;
  localparam logic [OP_W-1:0] OP_READ = 3'd1;
  localparam logic [OP_W-1:0] OP_LINE = 3'd2;
  localparam logic [OP_W-1:0] OP_RECT = 3'd3;
  localparam logic [OP_W-1:0] OP_CIRC = 3'd4;
  localparam logic [OP_W-1:0] OP_DISC = 3'd5;

  localparam logic [COLOR_W-1:0] READ_MISS = 16'hFFFF;

  typedef enum logic [2:0] {
    K_NONE, K_PLOT, K_READ, K_LINE, K_RECT, K_CIRC, K_DISC
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [COORD_W-1:0]   x_a;
    logic [COORD_W-1:0]   y_a;
    logic [COORD_W-1:0]   x_b;
    logic [COORD_W-1:0]   y_b;
    logic [RAD_W-1:0]     radius;
    logic [COLOR_W-1:0]   color;
  } cmd_t;

  typedef enum logic [3:0] {
    B_CLEAR, B_IDLE, B_PLOT, B_RD_ADDR, B_RD_DATA, B_LINE_GO, B_LINE_WAIT,
    B_RECT, B_C_AX, B_C_L0W, B_C_CHECK, B_C_PTS, B_C_LW, B_DONE
  } bstate_t;

  typedef enum logic [1:0] {
    L_IDLE, L_ORDER, L_SETUP, L_RUN
  } lstate_t;

  typedef struct packed {
    logic               start;
    logic [COORD_W-1:0] xs;
    logic [COORD_W-1:0] ys;
    logic [COORD_W-1:0] xe;
    logic [COORD_W-1:0] ye;
  } line_req_t;

  typedef struct packed {
    logic               done;
    logic               rejected;
    logic               pv;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
  } line_rsp_t;

  function automatic logic [COORD_W-1:0] absdiff(input logic [COORD_W-1:0] a,
                                                 input logic [COORD_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/fbrd_ifc.sv =====
// Command and result channel interfaces, valid/ready with payload.
// Depends on fbrd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface fbrd_cmd_if;
  import fbrd_pkg::*;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [COORD_W-1:0] x_a;
  logic [COORD_W-1:0] y_a;
  logic [COORD_W-1:0] x_b;
  logic [COORD_W-1:0] y_b;
  logic [RAD_W-1:0]   radius;
  logic [COLOR_W-1:0] color;
  modport source(output valid, operation, x_a, y_a, x_b, y_b, radius, color,
                 input ready);
  modport sink(input valid, operation, x_a, y_a, x_b, y_b, radius, color,
               output ready);
endinterface

interface fbrd_res_if;
  import fbrd_pkg::*;
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] read_data;
  logic               line_rejected;
  modport source(output valid, read_data, line_rejected, input ready);
  modport sink(input valid, read_data, line_rejected, output ready);
endinterface
`default_nettype wire

// ===== hdl/fbrd_front.sv =====
// Front end: accepts commands, decodes the operation, holds a two-entry queue.
// Depends on fbrd_pkg and fbrd_cmd_if.
`timescale 1ns / 1ps
`default_nettype none
module fbrd_front (
  input  logic          clk,
  input  logic          rst_n,
  fbrd_cmd_if.sink      in_ch,
  input  logic          clearing,
  input  logic          q_pop,
  output logic          q_valid,
  output fbrd_pkg::cmd_t q_cmd
);
  import fbrd_pkg::*;

  cmd_t       q_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  cmd_t       entry;

  function automatic kind_t classify(input logic [OP_W-1:0] op);
    kind_t k;
    case (op)
      OP_PLOT: k = K_PLOT;
      OP_READ: k = K_READ;
      OP_LINE: k = K_LINE;
      OP_RECT: k = K_RECT;
      OP_CIRC: k = K_CIRC;
      OP_DISC: k = K_DISC;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  assign in_ch.ready = (cnt_r != 2'd2) && !clearing;
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != 2'd0);
  assign pop         = q_pop && q_valid;
  assign q_cmd       = q_r[rp_r];

  always_comb begin
    entry.kind   = classify(in_ch.operation);
    entry.x_a    = in_ch.x_a;
    entry.y_a    = in_ch.y_a;
    entry.x_b    = in_ch.x_b;
    entry.y_b    = in_ch.y_b;
    entry.radius = in_ch.radius;
    entry.color  = in_ch.color;
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= entry;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/fbrd_line.sv =====
// Bresenham line stepper: orders the end points, rejects a major span over FRAME_WIDTH, then yields one pixel a cycle.
// Depends on fbrd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fbrd_line #(
  parameter int FRAME_WIDTH = 240
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fbrd_pkg::line_req_t req,
  output fbrd_pkg::line_rsp_t rsp
);
  import fbrd_pkg::*;

  localparam int DW = $clog2(FRAME_WIDTH + 1);
  localparam int EW = DW + 1;

  lstate_t            st_r, st_nxt;
  logic [COORD_W-1:0] ax_r, ay_r, bx_r, by_r;
  logic [COORD_W-1:0] sx_r, sy_r, ex_r, ey_r;
  logic [COORD_W-1:0] sx_nxt, sy_nxt, ex_nxt, ey_nxt;
  logic               steep_r, steep_nxt, up_r, up_nxt;
  logic [COORD_W-1:0] px_r, px_nxt, yc_r, yc_nxt;
  logic signed [EW-1:0] err_r, err_nxt, e2;
  logic [DW-1:0]      dx_r, dx_nxt, dy_r, dy_nxt, cnt_r, cnt_nxt;
  logic [COORD_W-1:0] dx16, dy16, x0, y0, x1, y1;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      L_IDLE:  if (req.start) st_nxt = L_ORDER;
      L_ORDER: st_nxt = L_SETUP;
      L_SETUP: st_nxt = (dx16 > COORD_W'(FRAME_WIDTH)) ? L_IDLE : L_RUN;
      L_RUN:   if (cnt_r == '0) st_nxt = L_IDLE;
      default: st_nxt = L_IDLE;
    endcase
  end

  always_comb begin
    sx_nxt = sx_r; sy_nxt = sy_r; ex_nxt = ex_r; ey_nxt = ey_r;
    steep_nxt = steep_r; up_nxt = up_r;
    px_nxt = px_r; yc_nxt = yc_r; err_nxt = err_r;
    dx_nxt = dx_r; dy_nxt = dy_r; cnt_nxt = cnt_r;
    rsp = '0;
    dx16 = ex_r - sx_r;
    dy16 = absdiff(ey_r, sy_r);
    x0 = ax_r; y0 = ay_r; x1 = bx_r; y1 = by_r;
    e2 = err_r - $signed({1'b0, dy_r});
    case (st_r)
      L_ORDER: begin
        steep_nxt = absdiff(by_r, ay_r) > absdiff(bx_r, ax_r);
        if (steep_nxt) begin
          x0 = ay_r; y0 = ax_r; x1 = by_r; y1 = bx_r;
        end
        if (x0 > x1) begin
          sx_nxt = x1; sy_nxt = y1; ex_nxt = x0; ey_nxt = y0;
        end else begin
          sx_nxt = x0; sy_nxt = y0; ex_nxt = x1; ey_nxt = y1;
        end
      end
      L_SETUP: begin
        if (dx16 > COORD_W'(FRAME_WIDTH)) begin
          rsp.done     = 1'b1;
          rsp.rejected = 1'b1;
        end else begin
          dx_nxt  = DW'(dx16);
          dy_nxt  = DW'(dy16);
          cnt_nxt = DW'(dx16);
          err_nxt = $signed({1'b0, DW'(dx16 >> 1)});
          px_nxt  = sx_r;
          yc_nxt  = sy_r;
          up_nxt  = sy_r < ey_r;
        end
      end
      L_RUN: begin
        rsp.pv = 1'b1;
        rsp.px = steep_r ? yc_r : px_r;
        rsp.py = steep_r ? px_r : yc_r;
        if (e2 < 0) begin
          yc_nxt  = up_r ? yc_r + 16'd1 : yc_r - 16'd1;
          err_nxt = e2 + $signed({1'b0, dx_r});
        end else begin
          err_nxt = e2;
        end
        px_nxt  = px_r + 16'd1;
        cnt_nxt = cnt_r - 1'b1;
        rsp.done = (cnt_r == '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= L_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == L_IDLE && req.start) begin
      ax_r <= req.xs; ay_r <= req.ys; bx_r <= req.xe; by_r <= req.ye;
    end
    sx_r <= sx_nxt; sy_r <= sy_nxt; ex_r <= ex_nxt; ey_r <= ey_nxt;
    steep_r <= steep_nxt; up_r <= up_nxt;
    px_r <= px_nxt; yc_r <= yc_nxt; err_r <= err_nxt;
    dx_r <= dx_nxt; dy_r <= dy_nxt; cnt_r <= cnt_nxt;
  end
endmodule
`default_nettype wire

// ===== hdl/fbrd_back.sv =====
// Back end: command sequencer, rectangle and circle walkers, pixel store.
// Depends on fbrd_pkg, fbrd_res_if and fbrd_line.
`timescale 1ns / 1ps
`default_nettype none
module fbrd_back #(
  parameter int FRAME_WIDTH  = 240,
  parameter int FRAME_HEIGHT = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  fbrd_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           clearing,
  fbrd_res_if.source     out_ch
);
  import fbrd_pkg::*;

  localparam int PIX = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW  = $clog2(PIX);
  localparam int XW  = $clog2(FRAME_WIDTH);
  localparam int YW  = $clog2(FRAME_HEIGHT);

  bstate_t            state_r, state_nxt;
  cmd_t               cur_r, cur_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;
  logic [2:0]         pc_r, pc_nxt;
  logic [COORD_W-1:0] rx_r, rx_nxt, ry_r, ry_nxt;
  logic [RAD_W-1:0]   xo_r, xo_nxt, yo_r, yo_nxt;
  logic signed [15:0] f_r, f_nxt, f_a;
  logic signed [12:0] ddx_r, ddx_nxt, ddy_r, ddy_nxt, ddx_u, ddy_u;
  logic [COLOR_W-1:0] res_rd_r, res_rd_nxt;
  logic               res_rej_r, res_rej_nxt;
  logic               out_v_r, out_v_nxt, out_rej_r, out_rej_nxt;
  logic [COLOR_W-1:0] out_rd_r, out_rd_nxt;
  logic               preq_v_r;
  logic [COORD_W-1:0] preq_x_r, preq_y_r;
  logic               emit;
  logic [COORD_W-1:0] ex, ey;
  logic               rd_hit_r;
  logic [COLOR_W-1:0] rdata_r;
  logic [COLOR_W-1:0] mem [PIX];
  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [COLOR_W-1:0] wdata;
  line_req_t          lreq;
  line_rsp_t          lrsp;
  logic [COORD_W-1:0] cx, cy, r16, x16, y16;
  logic [COORD_W-1:0] cpx, cmx, cpy, cmy, cxpy, cxmy, cypx, cymx, cpr, cmr, cypr, cymr;
  logic               disc;

  fbrd_line #(.FRAME_WIDTH(FRAME_WIDTH)) u_line (
    .clk(clk), .rst_n(rst_n), .req(lreq), .rsp(lrsp)
  );

  function automatic logic [AW-1:0] pix_addr(input logic [COORD_W-1:0] x,
                                             input logic [COORD_W-1:0] y);
    return AW'(y[YW-1:0]) * AW'(FRAME_WIDTH) + AW'(x[XW-1:0]);
  endfunction

  assign cx   = cur_r.x_a;
  assign cy   = cur_r.y_a;
  assign r16  = COORD_W'(cur_r.radius);
  assign x16  = COORD_W'(xo_r);
  assign y16  = COORD_W'(yo_r);
  assign cpx  = cx + x16;  assign cmx  = cx - x16;
  assign cpy  = cy + y16;  assign cmy  = cy - y16;
  assign cxpy = cx + y16;  assign cxmy = cx - y16;
  assign cypx = cy + x16;  assign cymx = cy - x16;
  assign cpr  = cx + r16;  assign cmr  = cx - r16;
  assign cypr = cy + r16;  assign cymr = cy - r16;
  assign disc = (cur_r.kind == K_DISC);
  assign ddx_u = ddx_r + 13'sd2;
  assign ddy_u = ddy_r + 13'sd2;

  assign clearing             = (state_r == B_CLEAR);
  assign out_ch.valid         = out_v_r;
  assign out_ch.read_data     = out_rd_r;
  assign out_ch.line_rejected = out_rej_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_CLEAR: if (clr_r == AW'(PIX - 1)) state_nxt = B_IDLE;
      B_IDLE: begin
        if (q_valid) begin
          case (q_cmd.kind)
            K_PLOT:         state_nxt = B_PLOT;
            K_READ:         state_nxt = B_RD_ADDR;
            K_LINE:         state_nxt = B_LINE_GO;
            K_RECT:         state_nxt = B_RECT;
            K_CIRC, K_DISC: state_nxt = B_C_AX;
            default:        state_nxt = B_DONE;
          endcase
        end
      end
      B_PLOT:      state_nxt = B_DONE;
      B_RD_ADDR:   state_nxt = B_RD_DATA;
      B_RD_DATA:   state_nxt = B_DONE;
      B_LINE_GO:   state_nxt = B_LINE_WAIT;
      B_LINE_WAIT: if (lrsp.done) state_nxt = B_DONE;
      B_RECT: begin
        if (!(ry_r < cur_r.y_b && ry_r < COORD_W'(FRAME_HEIGHT))) state_nxt = B_DONE;
      end
      B_C_AX:  if (pc_r == 3'd3) state_nxt = disc ? B_C_L0W : B_C_CHECK;
      B_C_L0W: if (lrsp.done) state_nxt = B_C_CHECK;
      B_C_CHECK: state_nxt = (xo_r < yo_r) ? B_C_PTS : B_DONE;
      B_C_PTS: begin
        if (disc) state_nxt = B_C_LW;
        else if (pc_r == 3'd7) state_nxt = B_C_CHECK;
      end
      B_C_LW:  if (lrsp.done) state_nxt = (pc_r == 3'd3) ? B_C_CHECK : B_C_PTS;
      B_DONE:  if (!out_v_r || out_ch.ready) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    cur_nxt = cur_r; clr_nxt = clr_r; pc_nxt = pc_r;
    rx_nxt = rx_r; ry_nxt = ry_r; xo_nxt = xo_r; yo_nxt = yo_r;
    f_nxt = f_r; ddx_nxt = ddx_r; ddy_nxt = ddy_r;
    res_rd_nxt = res_rd_r; res_rej_nxt = res_rej_r;
    out_v_nxt = out_v_r && !out_ch.ready;
    out_rd_nxt = out_rd_r; out_rej_nxt = out_rej_r;
    q_pop = 1'b0;
    emit = 1'b0; ex = cx; ey = cy;
    lreq = '0;
    f_a = (f_r >= 16'sd0) ? f_r + 16'(ddy_u) : f_r;
    case (state_r)
      B_CLEAR: clr_nxt = clr_r + 1'b1;
      B_IDLE: begin
        if (q_valid) begin
          q_pop       = 1'b1;
          cur_nxt     = q_cmd;
          res_rd_nxt  = '0;
          res_rej_nxt = 1'b0;
          rx_nxt      = q_cmd.x_a;
          ry_nxt      = q_cmd.y_a;
          xo_nxt      = '0;
          yo_nxt      = q_cmd.radius;
          f_nxt       = 16'sd1 - $signed({6'd0, q_cmd.radius});
          ddx_nxt     = 13'sd1;
          ddy_nxt     = $signed(13'd0 - {2'd0, q_cmd.radius, 1'b0});
          pc_nxt      = 3'd0;
        end
      end
      B_PLOT: emit = 1'b1;
      B_RD_DATA: res_rd_nxt = rd_hit_r ? rdata_r : READ_MISS;
      B_LINE_GO: begin
        lreq.start = 1'b1;
        lreq.xs = cur_r.x_a; lreq.ys = cur_r.y_a;
        lreq.xe = cur_r.x_b; lreq.ye = cur_r.y_b;
      end
      B_LINE_WAIT: if (lrsp.done) res_rej_nxt = lrsp.rejected;
      B_RECT: begin
        if (ry_r < cur_r.y_b && ry_r < COORD_W'(FRAME_HEIGHT)) begin
          if (rx_r < cur_r.x_b && rx_r < COORD_W'(FRAME_WIDTH)) begin
            emit = 1'b1; ex = rx_r; ey = ry_r;
            rx_nxt = rx_r + 16'd1;
          end else begin
            ry_nxt = ry_r + 16'd1;
            rx_nxt = cur_r.x_a;
          end
        end
      end
      B_C_AX: begin
        emit = 1'b1;
        case (pc_r[1:0])
          2'd0:    begin ex = cx;  ey = cypr; end
          2'd1:    begin ex = cx;  ey = cymr; end
          2'd2:    begin ex = cpr; ey = cy;   end
          default: begin ex = cmr; ey = cy;   end
        endcase
        pc_nxt = (pc_r == 3'd3) ? 3'd0 : pc_r + 3'd1;
        if (pc_r == 3'd3 && disc) begin
          lreq.start = 1'b1;
          lreq.xs = cmr; lreq.ys = cy; lreq.xe = cpr; lreq.ye = cy;
        end
      end
      B_C_CHECK: begin
        if (xo_r < yo_r) begin
          if (f_r >= 16'sd0) begin
            yo_nxt  = yo_r - 1'b1;
            ddy_nxt = ddy_u;
          end
          xo_nxt  = xo_r + 1'b1;
          ddx_nxt = ddx_u;
          f_nxt   = f_a + 16'(ddx_u);
          pc_nxt  = 3'd0;
        end
      end
      B_C_PTS: begin
        if (disc) begin
          lreq.start = 1'b1;
          case (pc_r[1:0])
            2'd0: begin lreq.xs = cmx;  lreq.ys = cpy;  lreq.xe = cpx;  lreq.ye = cpy;  end
            2'd1: begin lreq.xs = cpx;  lreq.ys = cmy;  lreq.xe = cmx;  lreq.ye = cmy;  end
            2'd2: begin lreq.xs = cxpy; lreq.ys = cypx; lreq.xe = cxmy; lreq.ye = cypx; end
            default: begin
              lreq.xs = cxpy; lreq.ys = cymx; lreq.xe = cxmy; lreq.ye = cymx;
            end
          endcase
        end else begin
          emit = 1'b1;
          case (pc_r)
            3'd0:    begin ex = cpx;  ey = cpy;  end
            3'd1:    begin ex = cmx;  ey = cpy;  end
            3'd2:    begin ex = cpx;  ey = cmy;  end
            3'd3:    begin ex = cmx;  ey = cmy;  end
            3'd4:    begin ex = cxpy; ey = cypx; end
            3'd5:    begin ex = cxmy; ey = cypx; end
            3'd6:    begin ex = cxpy; ey = cymx; end
            default: begin ex = cxmy; ey = cymx; end
          endcase
          pc_nxt = pc_r + 3'd1;
        end
      end
      B_C_LW: if (lrsp.done) pc_nxt = pc_r + 3'd1;
      B_DONE: begin
        if (!out_v_r || out_ch.ready) begin
          out_v_nxt   = 1'b1;
          out_rd_nxt  = res_rd_r;
          out_rej_nxt = res_rej_r;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = clr_r;
    wdata = '0;
    raddr = pix_addr(cur_r.x_a, cur_r.y_a);
    if (state_r == B_CLEAR) begin
      we = 1'b1;
    end else if (preq_v_r && preq_x_r < COORD_W'(FRAME_WIDTH)
                 && preq_y_r < COORD_W'(FRAME_HEIGHT)) begin
      we    = 1'b1;
      waddr = pix_addr(preq_x_r, preq_y_r);
      wdata = cur_r.color;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r  <= mem[raddr];
    rd_hit_r <= cur_r.x_a < COORD_W'(FRAME_WIDTH) && cur_r.y_a < COORD_W'(FRAME_HEIGHT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_CLEAR;
      clr_r    <= '0;
      out_v_r  <= 1'b0;
      preq_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      out_v_r  <= out_v_nxt;
      preq_v_r <= emit || lrsp.pv;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt; pc_r <= pc_nxt;
    rx_r <= rx_nxt; ry_r <= ry_nxt; xo_r <= xo_nxt; yo_r <= yo_nxt;
    f_r <= f_nxt; ddx_r <= ddx_nxt; ddy_r <= ddy_nxt;
    res_rd_r <= res_rd_nxt; res_rej_r <= res_rej_nxt;
    out_rd_r <= out_rd_nxt; out_rej_r <= out_rej_nxt;
    preq_x_r <= lrsp.pv ? lrsp.px : ex;
    preq_y_r <= lrsp.pv ? lrsp.py : ey;
  end
endmodule
`default_nettype wire

// ===== hdl/framebuffer_raster_draw_engine_core.sv =====
// Raster draw engine top level: front queue and back sequencer with pixel store.
// Depends on fbrd_pkg, fbrd_ifc, fbrd_front and fbrd_back.
//
// in_ch carries one drawing command per transfer: plot, read, line, rectangle
// fill, circle outline or filled circle. out_ch returns exactly one result per
// command, in order: read_data for a read (0xFFFF off frame) and line_rejected
// for a line whose major span exceeds FRAME_WIDTH; both zero otherwise.
// A two-entry queue takes commands while the back end draws the current one.
// The back end writes at most one pixel per cycle into the store, which has
// a write port and a separate read port. A rectangle is filled row by row, an
// outline circle writes its four axis points and then eight points per octant
// step, and a filled circle adds an axis line and four line runs per step.
// After reset all FRAME_WIDTH*FRAME_HEIGHT pixels of the store are cleared,
// one pixel a cycle, while in_ch.ready stays low.
// A stalled out_ch holds its result; the back end then waits with the next
// result and the queue fills, dropping in_ch.ready when full.
`timescale 1ns / 1ps
`default_nettype none
module framebuffer_raster_draw_engine_core #(
  parameter int FRAME_WIDTH  = 240,
  parameter int FRAME_HEIGHT = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  fbrd_cmd_if.sink   in_ch,
  fbrd_res_if.source out_ch
);
  import fbrd_pkg::*;

  logic q_valid, q_pop, clearing;
  cmd_t q_cmd;

  fbrd_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .clearing(clearing),
    .q_pop(q_pop), .q_valid(q_valid), .q_cmd(q_cmd)
  );

  fbrd_back #(.FRAME_WIDTH(FRAME_WIDTH), .FRAME_HEIGHT(FRAME_HEIGHT)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_cmd(q_cmd),
    .q_pop(q_pop), .clearing(clearing), .out_ch(out_ch)
  );
endmodule
`default_nettype wire

// ===== hdl/fbrd_checker.sv =====
// Port-level checks for the raster draw engine, bound to the top level.
// Depends on framebuffer_raster_draw_engine_core port names only.
`timescale 1ns / 1ps
`default_nettype none
module fbrd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_read_data,
  input logic        out_line_rejected
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data)
      && $stable(out_line_rejected))
    else $error("stalled result changed");

  a_rej_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_line_rejected |-> out_read_data == 16'd0)
    else $error("rejected line carries read data");

  a_clear_blocks: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("command taken during clear");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");
endmodule

bind framebuffer_raster_draw_engine_core fbrd_checker u_fbrd_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_read_data(out_ch.read_data), .out_line_rejected(out_ch.line_rejected)
);
`default_nettype wire
